// ===== src/fqsq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fqsq_pkg
// Types and constants shared by the FIFO queue with scan queries.
// ----------------------------------------------------------------------------
package fqsq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int DATA_W    = 32;
  localparam int KIND_W    = 3;
  localparam int TALLY_W   = 5;
  localparam int STATUS_W  = 2;

  localparam logic [KIND_W-1:0] KIND_PUSH    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_POP     = 3'd1;
  localparam logic [KIND_W-1:0] KIND_GREATER = 3'd2;
  localparam logic [KIND_W-1:0] KIND_EVEN    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_REVERSE = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data_out;
    logic [TALLY_W-1:0]       tally;
    logic [STATUS_W-1:0]      status;
  } out_t;

  typedef struct packed {
    logic clr;
    logic en;
    logic gt;
  } scan_ctl_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP_RD,
    S_SCAN,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// ===== src/fqsq_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fqsq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fqsq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== src/fqsq_scan.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fqsq_scan
// Shared compare unit and hit counter for the count queries.
// ----------------------------------------------------------------------------
module fqsq_scan #(
  parameter int DEPTH = fqsq_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire fqsq_pkg::scan_ctl_t           ctl,
  input  wire logic [fqsq_pkg::DATA_W-1:0]   thr,
  input  wire logic [fqsq_pkg::DATA_W-1:0]   data,
  output logic      [$clog2(DEPTH+1)-1:0]    count
);
  import fqsq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  logic          hit;
  logic [CW-1:0] count_r;
  logic [CW-1:0] count_nxt;

  always_comb begin
    if (ctl.gt) begin
      hit = $signed(data) > $signed(thr);
    end else begin
      hit = ~data[0];
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.clr) begin
      count_nxt = '0;
    end else if (ctl.en && hit) begin
      count_nxt = count_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    count_r <= count_nxt;
  end

  assign count = count_r;

endmodule
`default_nettype wire

// ===== src/fqsq_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fqsq_ctrl
// Request sequencer: pointers, occupancy, store access and scan stepping.
// ----------------------------------------------------------------------------
module fqsq_ctrl #(
  parameter int DEPTH = fqsq_pkg::DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire fqsq_pkg::in_t                 in_data,
  input  wire logic                          res_free,
  output logic                               res_valid,
  output fqsq_pkg::out_t                     res,
  output logic                               ram_we,
  output logic [$clog2(DEPTH)-1:0]           ram_waddr,
  output logic [fqsq_pkg::DATA_W-1:0]        ram_wdata,
  output logic [$clog2(DEPTH)-1:0]           ram_raddr,
  input  wire logic [fqsq_pkg::DATA_W-1:0]   ram_rdata,
  output fqsq_pkg::scan_ctl_t                scan_ctl,
  output logic [fqsq_pkg::DATA_W-1:0]        scan_thr,
  input  wire logic [$clog2(DEPTH+1)-1:0]    scan_count
);
  import fqsq_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  function automatic logic [PW-1:0] slot_add(input logic [PW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[PW-1:0];
  endfunction

  state_t                  state_r, state_nxt;
  logic [KIND_W-1:0]       kind_r, kind_nxt;
  logic [DATA_W-1:0]       value_r, value_nxt;
  logic [PW-1:0]           head_r, head_nxt;
  logic [CW-1:0]           occ_r, occ_nxt;
  logic                    rev_r, rev_nxt;
  logic [CW-1:0]           idx_r, idx_nxt;
  logic                    rd_pend_r, rd_pend_nxt;
  logic [DATA_W-1:0]       data_r, data_nxt;
  logic [STATUS_W-1:0]     status_r, status_nxt;

  logic is_full;
  logic is_empty;
  logic is_count;
  logic scan_issue;

  assign is_full    = (occ_r == CW'(DEPTH));
  assign is_empty   = (occ_r == '0);
  assign is_count   = (kind_r == KIND_GREATER) || (kind_r == KIND_EVEN);
  assign scan_issue = (state_r == S_SCAN) && (idx_r != occ_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (kind_r)
          KIND_POP:     state_nxt = is_empty ? S_DONE : S_POP_RD;
          KIND_GREATER: state_nxt = S_SCAN;
          KIND_EVEN:    state_nxt = S_SCAN;
          default:      state_nxt = S_DONE;
        endcase
      end
      S_POP_RD: state_nxt = S_DONE;
      S_SCAN: begin
        if ((idx_r == occ_r) && !rd_pend_r) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (res_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall     = (state_r != S_IDLE);
    res_valid    = (state_r == S_DONE);
    ram_we       = 1'b0;
    ram_waddr    = rev_r ? slot_add(head_r, CW'(DEPTH - 1)) : slot_add(head_r, occ_r);
    ram_wdata    = value_r;
    ram_raddr    = slot_add(head_r, idx_r);
    scan_ctl.clr = (state_r == S_EXEC);
    scan_ctl.en  = (state_r == S_SCAN) && rd_pend_r;
    scan_ctl.gt  = (kind_r == KIND_GREATER);
    scan_thr     = value_r;
    if (state_r == S_EXEC) begin
      case (kind_r)
        KIND_PUSH: ram_we = !is_full;
        KIND_POP:  ram_raddr = rev_r ? slot_add(head_r, occ_r - CW'(1)) : head_r;
        default:   ram_we = 1'b0;
      endcase
    end
    res.data_out = data_r;
    res.tally    = is_count ? TALLY_W'(scan_count) : TALLY_W'(occ_r);
    res.status   = status_r;
  end

  // datapath
  always_comb begin
    kind_nxt    = kind_r;
    value_nxt   = value_r;
    head_nxt    = head_r;
    occ_nxt     = occ_r;
    rev_nxt     = rev_r;
    idx_nxt     = idx_r;
    rd_pend_nxt = 1'b0;
    data_nxt    = data_r;
    status_nxt  = status_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt   = in_data.kind;
          value_nxt  = in_data.value;
          idx_nxt    = '0;
          data_nxt   = '0;
          status_nxt = ST_OK;
        end
      end
      S_EXEC: begin
        case (kind_r)
          KIND_PUSH: begin
            if (is_full) begin
              status_nxt = ST_FULL;
            end else begin
              occ_nxt = occ_r + CW'(1);
              if (rev_r) begin
                head_nxt = slot_add(head_r, CW'(DEPTH - 1));
              end
            end
          end
          KIND_POP: begin
            if (is_empty) begin
              status_nxt = ST_EMPTY;
            end else begin
              occ_nxt = occ_r - CW'(1);
              if (!rev_r) begin
                head_nxt = slot_add(head_r, CW'(1));
              end
            end
          end
          KIND_REVERSE: rev_nxt = ~rev_r;
          default: rev_nxt = rev_r;
        endcase
      end
      S_POP_RD: data_nxt = ram_rdata;
      S_SCAN: begin
        if (scan_issue) begin
          idx_nxt     = idx_r + CW'(1);
          rd_pend_nxt = 1'b1;
        end
      end
      default: rd_pend_nxt = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      head_r    <= '0;
      occ_r     <= '0;
      rev_r     <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      head_r    <= head_nxt;
      occ_r     <= occ_nxt;
      rev_r     <= rev_nxt;
      rd_pend_r <= rd_pend_nxt;
    end
    kind_r   <= kind_nxt;
    value_r  <= value_nxt;
    idx_r    <= idx_nxt;
    data_r   <= data_nxt;
    status_r <= status_nxt;
  end

endmodule
`default_nettype wire

// ===== src/fifo_queue_with_scan_queries_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fifo_queue_with_scan_queries_top
// Bounded FIFO queue of signed words with push, pop, reverse and count scans.
// Push, reverse, unknown kinds and failed pop go from EXEC straight to DONE;
// a successful pop also reads the store in POP_RD; count queries step through
// every stored entry in SCAN before DONE.
// Throughput: one request at a time, the next transfer is taken only after the
// result is loaded; count scans read one stored entry per cycle.
// Reset (rst_n, synchronous): queue empty, normal order, no result pending.
// ----------------------------------------------------------------------------
module fifo_queue_with_scan_queries_top #(
  parameter int DEPTH = fqsq_pkg::DEPTH_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire fqsq_pkg::in_t  in_data,
  output logic                out_valid,
  input  wire logic           out_stall,
  output fqsq_pkg::out_t      out_data
);
  import fqsq_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic              res_free;
  logic              res_valid;
  out_t              res;
  logic              ram_we;
  logic [PW-1:0]     ram_waddr;
  logic [DATA_W-1:0] ram_wdata;
  logic [PW-1:0]     ram_raddr;
  logic [DATA_W-1:0] ram_rdata;
  scan_ctl_t         scan_ctl;
  logic [DATA_W-1:0] scan_thr;
  logic [CW-1:0]     scan_count;

  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, out_data_nxt;

  fqsq_ctrl #(.DEPTH(DEPTH)) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .res_free   (res_free),
    .res_valid  (res_valid),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .ram_raddr  (ram_raddr),
    .ram_rdata  (ram_rdata),
    .scan_ctl   (scan_ctl),
    .scan_thr   (scan_thr),
    .scan_count (scan_count)
  );

  fqsq_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  fqsq_scan #(.DEPTH(DEPTH)) u_scan (
    .clk   (clk),
    .ctl   (scan_ctl),
    .thr   (scan_thr),
    .data  (ram_rdata),
    .count (scan_count)
  );

  // result register
  assign res_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (res_valid && res_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire
